@@ hw/rtl/dfe_pkg.sv @@
// types, constants and codes shared by the frame extractor modules
`timescale 1ns / 1ps
package dfe_pkg;

    localparam int FRAME_DEPTH_DEF = 64;
    localparam int FILL_W          = 7;
    localparam int TIMEOUT_W       = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;
    localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [7:0] START_MARK = 8'h5E;
    localparam logic [7:0] END_MARK   = 8'h24;
    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_AW    = 2;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_ABORT    = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_LOAD = 2'd2
    } t_back_state;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_kind             kind;
        logic [FILL_W-1:0] count;
    } t_cmd;

endpackage

@@ hw/rtl/dfe_front.sv @@
// front end: accepts beats, tracks the frame and idle counter, issues commands
`timescale 1ns / 1ps
module dfe_front #(
    parameter int FRAME_DEPTH = dfe_pkg::FRAME_DEPTH_DEF,
    parameter int AW          = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dfe_pkg::t_in_item                 i_in,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dfe_pkg::TIMEOUT_W-1:0]     i_cfg_data,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output dfe_pkg::t_cmd                     o_q_cmd,
    input  logic                              i_replay_done,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic [7:0]                        o_wr_data
);

    logic                            r_in_frame, n_in_frame;
    logic [dfe_pkg::FILL_W-1:0]      r_fill, n_fill;
    logic [dfe_pkg::TIMEOUT_W-1:0]   r_idle, n_idle;
    logic [dfe_pkg::TIMEOUT_W-1:0]   r_timeout;
    logic                            r_pending, n_pending;
    logic                            accept;
    logic [dfe_pkg::TIMEOUT_W-1:0]   idle_inc;

    assign o_in_stall  = r_pending || i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;
    assign idle_inc    = (r_idle != dfe_pkg::IDLE_MAX) ? r_idle + 1'b1 : r_idle;

    always_comb begin
        n_in_frame = r_in_frame;
        n_fill     = r_fill;
        n_idle     = r_idle;
        n_pending  = r_pending;
        o_q_push   = 1'b0;
        o_q_cmd    = '{kind: dfe_pkg::KIND_EMPTY, count: '0};
        o_wr_en    = 1'b0;
        o_wr_addr  = r_fill[AW-1:0];
        o_wr_data  = i_in.rx_byte;
        if (i_replay_done) begin
            n_pending = 1'b0;
        end
        if (accept) begin
            if (i_in.action == dfe_pkg::ACT_TICK) begin
                n_idle = idle_inc;
                if (idle_inc > r_timeout && r_in_frame) begin
                    n_in_frame = 1'b0;
                    n_fill     = '0;
                    o_q_push   = 1'b1;
                    o_q_cmd    = '{kind: dfe_pkg::KIND_ABORT, count: '0};
                end
            end else begin
                n_idle = '0;
                if (i_in.rx_byte == dfe_pkg::START_MARK) begin
                    n_in_frame = 1'b1;
                    n_fill     = '0;
                end else if (r_in_frame) begin
                    if (i_in.rx_byte == dfe_pkg::END_MARK) begin
                        o_q_push   = 1'b1;
                        n_in_frame = 1'b0;
                        n_fill     = '0;
                        if (r_fill == '0) begin
                            o_q_cmd = '{kind: dfe_pkg::KIND_EMPTY, count: '0};
                        end else begin
                            o_q_cmd   = '{kind: dfe_pkg::KIND_BYTE, count: r_fill};
                            n_pending = 1'b1;
                        end
                    end else if (r_fill == dfe_pkg::FILL_W'(FRAME_DEPTH)) begin
                        o_q_push   = 1'b1;
                        o_q_cmd    = '{kind: dfe_pkg::KIND_OVERFLOW, count: '0};
                        n_in_frame = 1'b0;
                        n_fill     = '0;
                    end else begin
                        o_wr_en = 1'b1;
                        n_fill  = r_fill + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            r_idle     <= '0;
            r_pending  <= 1'b0;
            r_timeout  <= dfe_pkg::TIMEOUT_RESET;
        end else begin
            r_in_frame <= n_in_frame;
            r_fill     <= n_fill;
            r_idle     <= n_idle;
            r_pending  <= n_pending;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

endmodule

@@ hw/rtl/dfe_cmd_fifo.sv @@
// short command queue between front end and back end
`timescale 1ns / 1ps
module dfe_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dfe_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output dfe_pkg::t_cmd o_cmd
);

    dfe_pkg::t_cmd                 r_mem [dfe_pkg::CMD_Q_DEPTH];
    logic [dfe_pkg::CMD_Q_AW-1:0]  r_wr_ptr;
    logic [dfe_pkg::CMD_Q_AW-1:0]  r_rd_ptr;
    logic [dfe_pkg::CMD_Q_AW:0]    r_count;
    logic                          do_push, do_pop;

    assign o_full  = r_count == (dfe_pkg::CMD_Q_AW + 1)'(dfe_pkg::CMD_Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/dfe_back.sv @@
// back end: frame store, replay sequencer and output register
`timescale 1ns / 1ps
module dfe_back #(
    parameter int FRAME_DEPTH = dfe_pkg::FRAME_DEPTH_DEF,
    parameter int AW          = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [7:0]            i_wr_data,
    input  logic                  i_q_empty,
    input  dfe_pkg::t_cmd         i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_replay_done,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dfe_pkg::t_out_item    o_out
);

    logic [7:0]                 r_store [FRAME_DEPTH];
    logic [7:0]                 r_rd_data;
    dfe_pkg::t_back_state       r_state, n_state;
    logic [dfe_pkg::FILL_W-1:0] r_idx, n_idx;
    logic [dfe_pkg::FILL_W-1:0] r_cnt, n_cnt;
    logic                       r_out_valid;
    dfe_pkg::t_out_item         r_out, n_out;
    logic                       out_free, load;
    logic [dfe_pkg::FILL_W-1:0] idx_inc;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign idx_inc     = r_idx + 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // frame store
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_store[r_idx[AW-1:0]];
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_out         = r_out;
        load          = 1'b0;
        o_q_pop       = 1'b0;
        o_replay_done = 1'b0;
        case (r_state)
            dfe_pkg::BK_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.kind == dfe_pkg::KIND_BYTE) begin
                        n_cnt   = i_q_cmd.count;
                        n_idx   = '0;
                        n_state = dfe_pkg::BK_READ;
                    end else begin
                        load  = 1'b1;
                        n_out = '{kind: i_q_cmd.kind, payload_byte: 8'd0, last: 1'b1};
                    end
                end
            end
            dfe_pkg::BK_READ: begin
                n_state = dfe_pkg::BK_LOAD;
            end
            dfe_pkg::BK_LOAD: begin
                if (out_free) begin
                    load  = 1'b1;
                    n_out = '{kind: dfe_pkg::KIND_BYTE, payload_byte: r_rd_data,
                              last: idx_inc == r_cnt};
                    if (idx_inc == r_cnt) begin
                        o_replay_done = 1'b1;
                        n_state       = dfe_pkg::BK_IDLE;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = dfe_pkg::BK_READ;
                    end
                end
            end
            default: begin
                n_state = dfe_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dfe_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            if (out_free) begin
                r_out_valid <= load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

@@ hw/rtl/delimited_frame_extractor_unit.sv @@
// top level of the delimited frame extractor
// order: a status beat passes the command queue and then the output register; each
// payload beat of a replay passes BK_READ (frame store read), BK_LOAD and the output register
// throughput: one input beat per cycle; input stalled while a replay runs or the queue is full
// reset: synchronous active low; clears frame state, idle counter, queue, output valid
// and sets the idle timeout to 200; the frame store is not cleared
`timescale 1ns / 1ps
module delimited_frame_extractor_unit #(
    parameter int FRAME_DEPTH = dfe_pkg::FRAME_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dfe_pkg::t_in_item             i_in,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dfe_pkg::TIMEOUT_W-1:0] i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dfe_pkg::t_out_item            o_out
);

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    logic          q_full, q_empty, q_push, q_pop, replay_done;
    dfe_pkg::t_cmd q_in_cmd, q_out_cmd;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    dfe_front #(.FRAME_DEPTH(FRAME_DEPTH), .AW(AW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in_cmd),
        .i_replay_done (replay_done),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    dfe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out_cmd)
    );

    dfe_back #(.FRAME_DEPTH(FRAME_DEPTH), .AW(AW)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_data     (wr_data),
        .i_q_empty     (q_empty),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .o_replay_done (replay_done),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (o_out)
    );

endmodule

@@ hw/rtl/dfe_checker.sv @@
// port level checks for the frame extractor, bound to the top level
`timescale 1ns / 1ps
module dfe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input dfe_pkg::t_in_item             i_in,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [dfe_pkg::TIMEOUT_W-1:0] i_cfg_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input dfe_pkg::t_out_item            o_out
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

    // status beats are single and carry no byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind != dfe_pkg::KIND_BYTE |->
            o_out.last && o_out.payload_byte == 8'd0)
        else $error("status beat without last or with payload");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind delimited_frame_extractor_unit dfe_checker u_dfe_checker (.*);
